[rtl/core/hsgd_pkg.sv]
`default_nettype none

package hsgd_pkg;

	localparam int MAX_HANDS_DEF = 16;
	localparam int TRAIL_LEN_DEF = 10;

	localparam int POS_W = 16;
	localparam int SPEED_W = 10;
	localparam int QUIET_W = 8;
	localparam int SPEED_MAX = 1023;
	localparam int CFG_DATA_W = 10;

	localparam int FAST_SPEED_RST = 30;
	localparam int STILL_SPEED_RST = 5;
	localparam int QUIET_FRAMES_RST = 3;

	localparam logic [1:0] REG_FAST_SPEED = 2'd0;
	localparam logic [1:0] REG_STILL_SPEED = 2'd1;
	localparam logic [1:0] REG_QUIET_FRAMES = 2'd2;

	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_UPDATE = 2'd1;
	localparam logic [1:0] MODE_DESTROY = 2'd2;

	localparam logic [2:0] GEST_NONE = 3'd0;
	localparam logic [2:0] GEST_LEFT = 3'd1;
	localparam logic [2:0] GEST_RIGHT = 3'd2;
	localparam logic [2:0] GEST_UP = 3'd3;
	localparam logic [2:0] GEST_DOWN = 3'd4;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] hand_slot;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} hsgd_req_t;

	typedef struct packed {
		logic status;
		logic gesture_issued;
		logic [2:0] gesture_code;
		logic signed [POS_W-1:0] start_x;
		logic signed [POS_W-1:0] start_y;
		logic signed [POS_W-1:0] start_z;
	} hsgd_rsp_t;

endpackage

`default_nettype wire

[rtl/core/hsgd_ram.sv]
`default_nettype none

module hsgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/core/hand_swipe_gesture_detector.sv]
`default_nettype none

// Tracks up to MAX_HANDS hands by slot and reports horizontal and vertical swipes. Each request
// (create, update or destroy) gives exactly one response, presented from the output register
// after the request has passed stages one and two.
// The block takes one request per clock while the output is not stalled, except that a request
// to a slot that an earlier request still holds in the first two stages waits until that one has
// moved on, since the slot record is read on entry and written back only at the end of stage two.
// Trail points live in one memory of MAX_HANDS*TRAIL_LEN entries and the per-slot head, fill,
// gesture state and quiet count in a second memory of MAX_HANDS entries; both are defined by the
// create that opens a slot, so there is no clearing pass after reset. Configuration registers take
// effect on the next request and are to be written only while no request is in flight.
module hand_swipe_gesture_detector import hsgd_pkg::*; #(
	parameter int MAX_HANDS = MAX_HANDS_DEF,
	parameter int TRAIL_LEN = TRAIL_LEN_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire hsgd_req_t             in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output hsgd_rsp_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SLOT_W = (MAX_HANDS > 1) ? $clog2(MAX_HANDS) : 1;
	localparam int HEAD_W = $clog2(TRAIL_LEN);
	localparam int FILL_W = $clog2(TRAIL_LEN + 1);
	localparam int TA_DEPTH = MAX_HANDS * TRAIL_LEN;
	localparam int TA_W = $clog2(TA_DEPTH);
	localparam int LIM_W = $clog2(SPEED_MAX * TRAIL_LEN + 1);
	localparam int DIFF_W = POS_W + 1;
	localparam int CMP_W = (LIM_W > DIFF_W) ? LIM_W : DIFF_W;

	typedef struct packed {
		logic [HEAD_W-1:0]  head;
		logic [FILL_W-1:0]  fill;
		logic [2:0]         state;
		logic [QUIET_W-1:0] quiet;
	} rec_t;

	logic [LIM_W-1:0]   fast_lim_q;
	logic [LIM_W-1:0]   still_lim_q;
	logic [QUIET_W-1:0] quiet_frames_q;

	logic [MAX_HANDS-1:0] slot_valid_q;

	logic       v_s1;
	hsgd_req_t  req_s1;
	logic       rng_s1;

	logic               v_s2;
	logic [3:0]         slot_s2;
	logic [SLOT_W-1:0]  slot_idx_s2;
	logic               create_s2;
	logic               upd_s2;
	logic               bad_s2;
	point_t             pos_s2;
	logic [HEAD_W-1:0]  head_s2;
	logic [FILL_W-1:0]  fill_s2;
	logic [2:0]         state_s2;
	logic [QUIET_W-1:0] quiet_s2;

	logic      out_v_q;
	hsgd_rsp_t rsp_q;

	logic en1;
	logic en2;
	logic hazard;
	logic accept;
	logic in_rng;

	rec_t               rec_rd;
	rec_t               rec_wr;
	logic               rec_we;
	logic [SLOT_W-1:0]  slot_idx_s1;
	logic               vld_s1;
	logic               create_s1;
	logic               upd_s1;
	logic               dst_s1;
	logic               bad_s1;
	logic [HEAD_W-1:0]  wr_idx_s1;
	logic [HEAD_W-1:0]  head_new_s1;
	logic [FILL_W-1:0]  fill_new_s1;
	logic [HEAD_W-1:0]  old_idx_s1;
	logic [TA_W-1:0]    slot_base_s1;
	logic [TA_W-1:0]    trail_waddr;
	logic [TA_W-1:0]    trail_raddr;
	logic               trail_we;
	point_t             trail_wdata;
	point_t             oldest;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]        adx;
	logic [DIFF_W-1:0]        ady;
	logic [CMP_W-1:0]         adx_c;
	logic [CMP_W-1:0]         ady_c;
	logic [CMP_W-1:0]         fast_c;
	logic [CMP_W-1:0]         still_c;
	logic                     horiz;
	logic                     vert;
	logic [2:0]               det;
	logic [QUIET_W-1:0]       quiet_inc;
	logic [QUIET_W-1:0]       quiet_new;
	logic [2:0]               state_mid;
	logic [2:0]               state_new;
	logic                     issue;
	hsgd_rsp_t                rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_lim_q <= LIM_W'(FAST_SPEED_RST * TRAIL_LEN);
			still_lim_q <= LIM_W'(STILL_SPEED_RST * TRAIL_LEN);
			quiet_frames_q <= QUIET_W'(QUIET_FRAMES_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FAST_SPEED: fast_lim_q <= LIM_W'(cfg_wdata * TRAIL_LEN);
				REG_STILL_SPEED: still_lim_q <= LIM_W'(cfg_wdata * TRAIL_LEN);
				REG_QUIET_FRAMES: quiet_frames_q <= cfg_wdata[QUIET_W-1:0];
				default: ;
			endcase
		end
	end

	assign en2 = !v_s2 || !out_v_q || out_ready;
	assign en1 = !v_s1 || en2;
	assign hazard = (v_s1 && (req_s1.hand_slot == in_data.hand_slot))
		|| (v_s2 && (slot_s2 == in_data.hand_slot));
	assign in_ready = en1 && !hazard;
	assign accept = in_valid && in_ready;
	assign in_rng = 32'(in_data.hand_slot) < MAX_HANDS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1 <= in_data;
			rng_s1 <= in_rng;
		end
	end

	hsgd_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(MAX_HANDS)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(slot_idx_s2),
		.wdata(rec_wr),
		.re   (en1),
		.raddr(SLOT_W'(in_data.hand_slot)),
		.rdata(rec_rd)
	);

	assign slot_idx_s1 = SLOT_W'(req_s1.hand_slot);
	assign vld_s1 = rng_s1 && slot_valid_q[slot_idx_s1];
	assign create_s1 = (req_s1.mode == MODE_CREATE) && rng_s1;
	assign upd_s1 = (req_s1.mode == MODE_UPDATE) && vld_s1;
	assign dst_s1 = (req_s1.mode == MODE_DESTROY) && vld_s1;
	assign bad_s1 = ((req_s1.mode == MODE_UPDATE) || (req_s1.mode == MODE_DESTROY)) && !vld_s1;

	// The oldest point sits at slot entry zero until the ring is full, then right after the head.
	assign wr_idx_s1 = create_s1 ? '0 : rec_rd.head;
	assign head_new_s1 = (wr_idx_s1 == HEAD_W'(TRAIL_LEN - 1)) ? '0 : wr_idx_s1 + HEAD_W'(1);
	assign fill_new_s1 = create_s1 ? FILL_W'(1)
		: (rec_rd.fill < FILL_W'(TRAIL_LEN)) ? rec_rd.fill + FILL_W'(1) : rec_rd.fill;
	assign old_idx_s1 = (fill_new_s1 < FILL_W'(TRAIL_LEN)) ? '0 : head_new_s1;
	assign slot_base_s1 = TA_W'(slot_idx_s1) * TA_W'(TRAIL_LEN);
	assign trail_waddr = slot_base_s1 + TA_W'(wr_idx_s1);
	assign trail_raddr = slot_base_s1 + TA_W'(old_idx_s1);
	assign trail_we = en2 && v_s1 && (create_s1 || upd_s1);
	assign trail_wdata = '{x: req_s1.pos_x, y: req_s1.pos_y, z: req_s1.pos_z};

	hsgd_ram #(
		.WIDTH($bits(point_t)),
		.DEPTH(TA_DEPTH)
	) u_trail_ram (
		.clk  (clk),
		.we   (trail_we),
		.waddr(trail_waddr),
		.wdata(trail_wdata),
		.re   (en2),
		.raddr(trail_raddr),
		.rdata(oldest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (en2 && v_s1) begin
			if (create_s1) begin
				slot_valid_q[slot_idx_s1] <= 1'b1;
			end else if (dst_s1) begin
				slot_valid_q[slot_idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			slot_s2 <= req_s1.hand_slot;
			slot_idx_s2 <= slot_idx_s1;
			create_s2 <= create_s1;
			upd_s2 <= upd_s1;
			bad_s2 <= bad_s1;
			pos_s2 <= trail_wdata;
			head_s2 <= head_new_s1;
			fill_s2 <= fill_new_s1;
			state_s2 <= rec_rd.state;
			quiet_s2 <= rec_rd.quiet;
		end
	end

	assign dx = DIFF_W'(oldest.x) - DIFF_W'(pos_s2.x);
	assign dy = DIFF_W'(oldest.y) - DIFF_W'(pos_s2.y);
	assign adx = dx[DIFF_W-1] ? -dx : dx;
	assign ady = dy[DIFF_W-1] ? -dy : dy;
	assign adx_c = CMP_W'(adx);
	assign ady_c = CMP_W'(ady);
	assign fast_c = CMP_W'(fast_lim_q);
	assign still_c = CMP_W'(still_lim_q);
	assign horiz = (adx_c > fast_c) && (ady_c < still_c);
	assign vert = (adx_c < still_c) && (ady_c > fast_c);

	always_comb begin
		priority if (horiz) begin
			det = (!dx[DIFF_W-1] && (dx != '0)) ? GEST_LEFT : GEST_RIGHT;
		end else if (vert) begin
			det = (!dy[DIFF_W-1] && (dy != '0)) ? GEST_DOWN : GEST_UP;
		end else begin
			det = GEST_NONE;
		end
	end

	assign quiet_inc = (quiet_s2 == '1) ? quiet_s2 : quiet_s2 + QUIET_W'(1);

	always_comb begin
		if (det == GEST_NONE) begin
			quiet_new = quiet_inc;
			state_mid = (quiet_inc > quiet_frames_q) ? GEST_NONE : state_s2;
			issue = 1'b0;
		end else begin
			quiet_new = '0;
			state_mid = state_s2;
			issue = (state_s2 == GEST_NONE) ? (quiet_s2 > quiet_frames_q) : (state_s2 != det);
		end
		state_new = (issue || (state_mid == GEST_NONE)) ? det : state_mid;
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.status = bad_s2;
		if (upd_s2 && issue) begin
			rsp_d.gesture_issued = 1'b1;
			rsp_d.gesture_code = (state_s2 == GEST_NONE) ? det : state_s2;
			rsp_d.start_x = oldest.x;
			rsp_d.start_y = oldest.y;
			rsp_d.start_z = oldest.z;
		end
	end

	assign rec_we = en2 && v_s2 && (create_s2 || upd_s2);
	assign rec_wr = '{
		head: head_s2,
		fill: fill_s2,
		state: create_s2 ? GEST_NONE : state_new,
		quiet: create_s2 ? '0 : quiet_new
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en2 && v_s2) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s2) begin
			rsp_q <= rsp_d;
		end
	end

	assign out_valid = out_v_q;
	assign out_data = rsp_q;

`ifndef SYNTHESIS
	a_issue_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.gesture_issued |-> !out_data.status
			&& (out_data.gesture_code != GEST_NONE))
		else $error("An issued gesture has an error status or no gesture code.");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.gesture_issued |-> (out_data.gesture_code == GEST_NONE)
			&& (out_data.start_x == '0) && (out_data.start_y == '0)
			&& (out_data.start_z == '0))
		else $error("A response without a gesture carries gesture fields.");

	a_slot_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 |-> req_s1.hand_slot != slot_s2)
		else $error("Two requests to the same slot are in the pipeline at once.");

	a_trail_ports: assert property (@(posedge clk) disable iff (!arst_n)
		trail_we && upd_s1 |-> trail_waddr != trail_raddr)
		else $error("An update reads the trail entry that it overwrites.");
`endif

endmodule

`default_nettype wire
